// ===== rtl/core/clf_pkg.sv =====
// ----------------------------------------------------------------------------
// clf_pkg
// Types and constants shared by the far clip line blocks.
// ----------------------------------------------------------------------------
package clf_pkg;

    localparam int unsigned CrdW = 24;
    localparam int unsigned HeadW = 16;
    localparam int unsigned DifW = CrdW + 1;

    // configuration register indexes
    localparam logic [2:0] REG_CAM_X = 3'd0;
    localparam logic [2:0] REG_CAM_Z = 3'd1;
    localparam logic [2:0] REG_HEAD_X = 3'd2;
    localparam logic [2:0] REG_HEAD_Z = 3'd3;
    localparam logic [2:0] REG_FAR_REQ = 3'd4;

    typedef enum logic {
        KIND_SEG,
        KIND_EMPTY
    } kind_t;

    typedef struct packed {
        logic signed [CrdW-1:0] seg_x1;
        logic signed [CrdW-1:0] seg_z1;
        logic signed [CrdW-1:0] seg_x2;
        logic signed [CrdW-1:0] seg_z2;
        logic                   final_seg;
        logic                   empty_set;
    } clf_in_t;

    typedef struct packed {
        logic [CrdW-1:0] far_dist;
        logic            hit_found;
    } clf_out_t;

    typedef struct packed {
        logic signed [CrdW-1:0]  cam_x;
        logic signed [CrdW-1:0]  cam_z;
        logic signed [HeadW-1:0] head_x;
        logic signed [HeadW-1:0] head_z;
        logic [CrdW-1:0]         far_request;
    } clf_cfg_t;

    // one classified segment, camera offsets already taken
    typedef struct packed {
        kind_t                  kind;
        logic                   final_seg;
        logic signed [DifW-1:0] dx;
        logic signed [DifW-1:0] dz;
        logic signed [DifW-1:0] ex;
        logic signed [DifW-1:0] ez;
    } clf_entry_t;

endpackage

// ===== rtl/core/clf_front.sv =====
// ----------------------------------------------------------------------------
// clf_front
// Classifies incoming items and forms the segment offsets.
// ----------------------------------------------------------------------------
module clf_front
    import clf_pkg::*;
(
    input  clf_in_t    in_data,
    input  clf_cfg_t   cfg,
    output clf_entry_t entry
);

    always_comb
    begin
        entry.kind      = in_data.empty_set ? KIND_EMPTY : KIND_SEG;
        entry.final_seg = in_data.final_seg;
        entry.dx = DifW'(in_data.seg_x1) - DifW'(cfg.cam_x);
        entry.dz = DifW'(in_data.seg_z1) - DifW'(cfg.cam_z);
        entry.ex = DifW'(in_data.seg_x2) - DifW'(in_data.seg_x1);
        entry.ez = DifW'(in_data.seg_z2) - DifW'(in_data.seg_z1);
    end

endmodule

// ===== rtl/core/clf_queue.sv =====
// ----------------------------------------------------------------------------
// clf_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module clf_queue
    import clf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  clf_entry_t push_data,
    input  logic       pop,
    output clf_entry_t head,
    output logic       full,
    output logic       empty
);

    clf_entry_t  mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/clf_back.sv =====
// ----------------------------------------------------------------------------
// clf_back
// Solves one segment against the ray with a shared multiplier and two
// restoring dividers, keeps the running minimum, drives the result register.
// ----------------------------------------------------------------------------
module clf_back
    import clf_pkg::*;
#(
    parameter logic [23:0] MinFar = 24'd2560
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  clf_cfg_t   cfg,
    input  logic       far_wr,
    input  logic [23:0] far_wdata,
    input  logic       q_empty,
    input  clf_entry_t q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output clf_out_t   out_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_CHK, S_DIV1,
        S_P0, S_P1, S_DIV2, S_UPD, S_FIN, S_OUT
    } state_t;

    state_t             state_reg;
    clf_entry_t         ent_reg;
    logic signed [41:0] acc_reg;
    logic signed [42:0] num_reg;
    logic signed [42:0] den_reg;
    logic [41:0]        rem1_reg;
    logic [15:0]        t_reg;
    logic [5:0]         cnt_reg;
    logic signed [42:0] p_reg;
    logic [41:0]        dvd_reg;
    logic [17:0]        rem2_reg;
    logic [41:0]        q_reg;
    logic [23:0]        run_min_reg;
    logic               any_hit_reg;
    logic               out_valid_reg;
    clf_out_t           out_reg;

    logic signed [16:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [41:0] prod;
    logic signed [42:0] num_n;
    logic signed [42:0] den_n;
    logic signed [42:0] p_n;
    logic [41:0]        r1_sh;
    logic [15:0]        hz_abs;
    logic [17:0]        d2;
    logic [18:0]        r2_sh;
    logic               r2_ge;
    logic [23:0]        far_clamped;

    always_comb
    begin
        case (state_reg)
            S_M0:
            begin
                mul_a = 17'(cfg.head_z);
                mul_b = ent_reg.dx;
            end
            S_M1:
            begin
                mul_a = 17'(cfg.head_x);
                mul_b = ent_reg.dz;
            end
            S_M2:
            begin
                mul_a = 17'(cfg.head_x);
                mul_b = ent_reg.ez;
            end
            S_M3:
            begin
                mul_a = 17'(cfg.head_z);
                mul_b = ent_reg.ex;
            end
            S_P0:
            begin
                mul_a = $signed({1'b0, t_reg});
                mul_b = ent_reg.ez;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign num_n = den_reg[42] ? -num_reg : num_reg;
    assign den_n = den_reg[42] ? -den_reg : den_reg;
    assign p_n   = cfg.head_z[15] ? -p_reg : p_reg;
    assign r1_sh = {rem1_reg[40:0], 1'b0};
    assign hz_abs = cfg.head_z[15] ? 16'(-cfg.head_z) : 16'(cfg.head_z);
    assign d2     = {hz_abs, 2'b00};
    assign r2_sh  = {rem2_reg, dvd_reg[41]};
    assign r2_ge  = (r2_sh >= {1'b0, d2});
    assign far_clamped = (cfg.far_request > MinFar) ? cfg.far_request : MinFar;

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ent_reg <= q_head;
            end
            S_M0, S_M2:
            begin
                acc_reg <= prod;
            end
            S_M1:
            begin
                num_reg <= 43'(acc_reg) - 43'(prod);
            end
            S_M3:
            begin
                den_reg <= 43'(acc_reg) - 43'(prod);
            end
            S_CHK:
            begin
                rem1_reg <= num_n[41:0];
                den_reg  <= den_n;
            end
            S_DIV1:
            begin
                if (r1_sh >= den_reg[41:0])
                begin
                    rem1_reg <= r1_sh - den_reg[41:0];
                    t_reg    <= {t_reg[14:0], 1'b1};
                end
                else
                begin
                    rem1_reg <= r1_sh;
                    t_reg    <= {t_reg[14:0], 1'b0};
                end
            end
            S_P0:
            begin
                p_reg <= {{2{ent_reg.dz[24]}}, ent_reg.dz, 16'd0} + 43'(prod);
            end
            S_P1:
            begin
                dvd_reg  <= p_n[41:0];
                rem2_reg <= '0;
            end
            S_DIV2:
            begin
                rem2_reg <= r2_ge ? 18'(r2_sh - {1'b0, d2}) : r2_sh[17:0];
                dvd_reg  <= {dvd_reg[40:0], 1'b0};
                q_reg    <= {q_reg[40:0], r2_ge};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            run_min_reg   <= 24'd2560;
            any_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (far_wr && !any_hit_reg)
            begin
                run_min_reg <= far_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= (q_head.kind == KIND_EMPTY) ? S_OUT : S_M0;
                    end
                end
                S_M0: state_reg <= S_M1;
                S_M1: state_reg <= S_M2;
                S_M2: state_reg <= S_M3;
                S_M3: state_reg <= S_CHK;
                S_CHK:
                begin
                    cnt_reg <= '0;
                    if (den_reg == '0 || cfg.head_z == '0 || num_n <= 0 || num_n >= den_n)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_DIV1;
                    end
                end
                S_DIV1:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd15)
                    begin
                        state_reg <= S_P0;
                    end
                end
                S_P0:
                begin
                    state_reg <= (t_reg == '0) ? S_FIN : S_P1;
                end
                S_P1:
                begin
                    cnt_reg   <= '0;
                    state_reg <= (p_n <= 0) ? S_FIN : S_DIV2;
                end
                S_DIV2:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd41)
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (q_reg != '0)
                    begin
                        any_hit_reg <= 1'b1;
                        if (q_reg[41:24] == '0 && q_reg[23:0] < run_min_reg)
                        begin
                            run_min_reg <= q_reg[23:0];
                        end
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    state_reg <= ent_reg.final_seg ? S_OUT : S_IDLE;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        if (ent_reg.kind == KIND_EMPTY)
                        begin
                            out_reg.far_dist  <= far_clamped;
                            out_reg.hit_found <= 1'b0;
                        end
                        else
                        begin
                            out_reg.far_dist  <= any_hit_reg ? run_min_reg
                                                             : cfg.far_request;
                            out_reg.hit_found <= any_hit_reg;
                        end
                        run_min_reg <= cfg.far_request;
                        any_hit_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/clip_line_far_plane.sv =====
// ----------------------------------------------------------------------------
// clip_line_far_plane
// Far clip distance of a ground-plane camera ray against streamed segments.
// ----------------------------------------------------------------------------
// Segments enter through the in channel into a two-entry queue and are solved
// one at a time by the back end. A segment that hits goes through the pop,
// four steps on the shared 17x25 multiplier for the two cross products, a
// check, the restoring divider for t, two steps to form the ray distance,
// the restoring divider for u, and the update and close states. Segments
// rejected early (zero divisor, t or u out of range) skip to the close
// state; an empty-set item goes straight from the pop to the result state. A
// final segment also goes through the result state, and a final or empty item
// also needs the result register free. Configuration may be
// written only while the block is idle; cfg_ready is always high. Writing
// far_request with no hit pending also reloads the running minimum.
// ----------------------------------------------------------------------------
module clip_line_far_plane
    import clf_pkg::*;
#(
    parameter logic [23:0] MIN_FAR = 24'd2560
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  clf_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output clf_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    clf_cfg_t   cfg_reg;
    clf_entry_t front_entry;
    clf_entry_t q_head;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic       in_xfer;
    logic       cfg_xfer;
    logic       far_wr;

    assign in_ready  = !q_full;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign far_wr    = cfg_xfer && (cfg_index == REG_FAR_REQ);

    // configuration registers; out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_x       <= '0;
            cfg_reg.cam_z       <= '0;
            cfg_reg.head_x      <= '0;
            cfg_reg.head_z      <= 16'sd16384;
            cfg_reg.far_request <= 24'd2560;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                REG_CAM_X:   cfg_reg.cam_x       <= cfg_data;
                REG_CAM_Z:   cfg_reg.cam_z       <= cfg_data;
                REG_HEAD_X:  cfg_reg.head_x      <= cfg_data[15:0];
                REG_HEAD_Z:  cfg_reg.head_z      <= cfg_data[15:0];
                REG_FAR_REQ: cfg_reg.far_request <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // front: classify and take camera/segment offsets
    clf_front u_front (
        .in_data (in_data),
        .cfg     (cfg_reg),
        .entry   (front_entry)
    );

    clf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer),
        .push_data (front_entry),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: intersection solve, running minimum, result register
    clf_back #(
        .MinFar (MIN_FAR)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .far_wr    (far_wr),
        .far_wdata (cfg_data),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
